// ===== sv/pas_pkg.sv =====
// ----------------------------------------------------------------------------
// pas_pkg: shared types and constants
// Operation codes, field widths and the command and status words that pass
// between the controller and the datapath of the polynomial unit.
// ----------------------------------------------------------------------------
package pas_pkg;

  localparam int FUNC_W = 3;
  localparam int COEF_W = 16;
  localparam int PROD_W = 2 * COEF_W;
  localparam int OUT_W  = 40;

  // operation codes carried by the func field
  typedef enum logic [FUNC_W-1:0] {
    FN_LOAD_A = 3'd0,
    FN_LOAD_B = 3'd1,
    FN_ADD    = 3'd2,
    FN_SUB    = 3'd3,
    FN_MUL    = 3'd4
  } func_t;

  // one step of work for the datapath
  typedef struct packed {
    logic we_a;       // write coefficient into store a
    logic we_b;       // write coefficient into store b
    logic rd_en;      // read both stores, term enters the pipeline
    logic use_a;      // a term present, else zero
    logic use_b;      // b term present, else zero
    logic is_mul;     // product term
    logic is_sub;     // difference term
    logic first;      // first term of a coefficient, clears accumulator
    logic last_step;  // last term of a coefficient, loads output register
    logic last_coef;  // final coefficient of the run
  } dp_cmd_t;

  // datapath state seen by the controller
  typedef struct packed {
    logic busy;       // terms still in flight
    logic out_valid;  // output register holds a word
  } dp_status_t;

endpackage

// ===== sv/pas_in_if.sv =====
// ----------------------------------------------------------------------------
// pas_in_if: input channel
// Valid/ready channel carrying operation code and coefficient.
// ----------------------------------------------------------------------------
interface pas_in_if;
  logic                              valid;
  logic                              ready;
  logic [pas_pkg::FUNC_W-1:0]        func;
  logic signed [pas_pkg::COEF_W-1:0] coef_in;

  modport source (output valid, output func, output coef_in, input ready);
  modport sink   (input valid, input func, input coef_in, output ready);
endinterface

// ===== sv/pas_out_if.sv =====
// ----------------------------------------------------------------------------
// pas_out_if: output channel
// Valid/ready channel carrying result coefficients and the end marker.
// ----------------------------------------------------------------------------
interface pas_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [pas_pkg::OUT_W-1:0] coef_out;
  logic                             last_coef;

  modport source (output valid, output coef_out, output last_coef, input ready);
  modport sink   (input valid, input coef_out, input last_coef, output ready);
endinterface

// ===== sv/polynomial_add_sub_mul_unit.sv =====
// ----------------------------------------------------------------------------
// polynomial_add_sub_mul_unit: polynomial add, subtract and multiply
// Load words fill operand stores a and b; a compute word emits the sum,
// difference or convolution product, highest degree first.
// ----------------------------------------------------------------------------
// Load words are taken one word per cycle.
// Add/sub: each result word passes a store read, the term stage and the accumulate step.
// Multiply: 2L-1 result words, each built by the single shared multiply-accumulate
// walking the L terms of its degree.
// Input is not taken while a compute run is in progress.
// Reset (synchronous): lengths zero, pipeline empty; store contents undefined.
// ----------------------------------------------------------------------------
module polynomial_add_sub_mul_unit #(
  parameter int MAX_TERMS = 32
) (
  input logic      clk,
  input logic      rst,
  pas_in_if.sink   in_ch,
  pas_out_if.source out_ch
);

  localparam int AddrW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

  pas_pkg::dp_cmd_t                 cmd;
  pas_pkg::dp_status_t              sts;
  logic [AddrW-1:0]                 waddr;
  logic [AddrW-1:0]                 raddr_a;
  logic [AddrW-1:0]                 raddr_b;
  logic                             in_ready;
  logic                             out_valid;
  logic signed [pas_pkg::OUT_W-1:0] coef_out;
  logic                             last_coef;

  // controller
  pas_ctrl #(.MAX_TERMS(MAX_TERMS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .func      (in_ch.func),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd),
    .waddr     (waddr),
    .raddr_a   (raddr_a),
    .raddr_b   (raddr_b)
  );

  // datapath
  pas_dp #(.MAX_TERMS(MAX_TERMS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .coef_in   (in_ch.coef_in),
    .cmd       (cmd),
    .waddr     (waddr),
    .raddr_a   (raddr_a),
    .raddr_b   (raddr_b),
    .out_ready (out_ch.ready),
    .coef_out  (coef_out),
    .last_coef (last_coef),
    .out_valid (out_valid),
    .sts       (sts)
  );

  assign in_ch.ready      = in_ready;
  assign out_ch.valid     = out_valid;
  assign out_ch.coef_out  = coef_out;
  assign out_ch.last_coef = last_coef;

endmodule

// ===== sv/pas_ram.sv =====
// ----------------------------------------------------------------------------
// pas_ram: generic single-port-write ram
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pas_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/pas_dp.sv =====
// ----------------------------------------------------------------------------
// pas_dp: operand stores and multiply-accumulate datapath
// Two operand rams, a term stage (product or sum/difference), an
// accumulator and the output register.
// ----------------------------------------------------------------------------
module pas_dp #(
  parameter int MAX_TERMS = 32,
  localparam int AddrW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic signed [pas_pkg::COEF_W-1:0] coef_in,
  input  pas_pkg::dp_cmd_t                  cmd,
  input  logic [AddrW-1:0]                  waddr,
  input  logic [AddrW-1:0]                  raddr_a,
  input  logic [AddrW-1:0]                  raddr_b,
  input  logic                              out_ready,
  output logic signed [pas_pkg::OUT_W-1:0]  coef_out,
  output logic                              last_coef,
  output logic                              out_valid,
  output pas_pkg::dp_status_t               sts
);

  logic [pas_pkg::COEF_W-1:0]        a_rd;
  logic [pas_pkg::COEF_W-1:0]        b_rd;
  logic                              s1_valid;
  pas_pkg::dp_cmd_t                  s1_ctl;
  logic signed [pas_pkg::COEF_W-1:0] a_val;
  logic signed [pas_pkg::COEF_W-1:0] b_val;
  logic signed [pas_pkg::PROD_W-1:0] prod;
  logic signed [pas_pkg::COEF_W:0]   sum;
  logic                              s2_valid;
  pas_pkg::dp_cmd_t                  s2_ctl;
  logic signed [pas_pkg::OUT_W-1:0]  s2_term;
  logic signed [pas_pkg::OUT_W-1:0]  acc;
  logic signed [pas_pkg::OUT_W-1:0]  acc_next;

  // operand stores
  pas_ram #(.WIDTH(pas_pkg::COEF_W), .DEPTH(MAX_TERMS)) u_a_ram (
    .clk   (clk),
    .we    (cmd.we_a),
    .waddr (waddr),
    .wdata (coef_in),
    .raddr (raddr_a),
    .rdata (a_rd)
  );

  pas_ram #(.WIDTH(pas_pkg::COEF_W), .DEPTH(MAX_TERMS)) u_b_ram (
    .clk   (clk),
    .we    (cmd.we_b),
    .waddr (waddr),
    .wdata (coef_in),
    .raddr (raddr_b),
    .rdata (b_rd)
  );

  // read stage, control travels with the ram access
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.rd_en;
    end
    s1_ctl <= cmd;
  end

  // term stage: missing terms read as zero
  always_comb begin
    a_val = s1_ctl.use_a ? $signed(a_rd) : '0;
    b_val = s1_ctl.use_b ? $signed(b_rd) : '0;
    prod  = a_val * b_val;
    if (s1_ctl.is_sub) begin
      sum = {a_val[pas_pkg::COEF_W-1], a_val} - {b_val[pas_pkg::COEF_W-1], b_val};
    end else begin
      sum = {a_val[pas_pkg::COEF_W-1], a_val} + {b_val[pas_pkg::COEF_W-1], b_val};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_ctl  <= s1_ctl;
    s2_term <= s1_ctl.is_mul ? pas_pkg::OUT_W'(prod) : pas_pkg::OUT_W'(sum);
  end

  // accumulate, the last term of a coefficient loads the output register
  assign acc_next = (s2_ctl.first ? '0 : acc) + s2_term;

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      acc <= acc_next;
    end
    if (s2_valid && s2_ctl.last_step) begin
      coef_out  <= acc_next;
      last_coef <= s2_ctl.last_coef;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_valid && s2_ctl.last_step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign sts.busy      = s1_valid | s2_valid;
  assign sts.out_valid = out_valid;

  // a finished coefficient never lands on a word still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && s2_ctl.last_step) |-> (!out_valid || out_ready))
    else $error("result overwrites a pending output word");

  // output word appears only from a finished accumulation
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s2_valid && s2_ctl.last_step))
    else $error("output word without a finished coefficient");

  // stores are never written while being read
  a_no_rw_mix: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |-> !(cmd.we_a || cmd.we_b))
    else $error("store write during a read step");

endmodule

// ===== sv/pas_ctrl.sv =====
// ----------------------------------------------------------------------------
// pas_ctrl: sequencing controller
// Keeps the operand lengths, decodes input words and steps through the
// output degrees and the terms of each convolution sum.
// ----------------------------------------------------------------------------
module pas_ctrl #(
  parameter int MAX_TERMS = 32,
  localparam int CntW  = $clog2(MAX_TERMS + 1),
  localparam int AddrW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1,
  localparam int DegW  = CntW + 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [pas_pkg::FUNC_W-1:0] func,
  input  logic                       out_ready,
  input  pas_pkg::dp_status_t        sts,
  output pas_pkg::dp_cmd_t           cmd,
  output logic [AddrW-1:0]           waddr,
  output logic [AddrW-1:0]           raddr_a,
  output logic [AddrW-1:0]           raddr_b
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WAIT = 3'b010,
    S_RUN  = 3'b100
  } state_t;

  state_t          state;
  logic [CntW-1:0] a_count;
  logic [CntW-1:0] b_count;
  logic [CntW-1:0] len;
  logic [DegW-1:0] deg;
  logic [CntW-1:0] step;
  logic            is_mul;
  logic            is_sub;
  logic            done;

  logic            accept;
  logic [CntW-1:0] max_cnt;
  logic [CntW-1:0] len_start;
  logic [DegW:0]   j_deg;
  logic            use_mul;
  logic            use_a_add;
  logic            use_b_add;
  logic            last_step;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // common length, the empty case runs as one zero coefficient
  assign max_cnt   = (a_count > b_count) ? a_count : b_count;
  assign len_start = (max_cnt == '0) ? CntW'(1) : max_cnt;

  // b degree of the current product term, may go negative
  assign j_deg   = {1'b0, deg} - {2'b00, step};
  assign use_mul = (step < a_count) && !j_deg[DegW] &&
                   (j_deg[DegW-1:0] < {1'b0, b_count});
  assign use_a_add = deg < {1'b0, a_count};
  assign use_b_add = deg < {1'b0, b_count};
  assign last_step = !is_mul || (step == len - CntW'(1));

  // command word for the datapath
  always_comb begin
    cmd       = '0;
    waddr     = '0;
    raddr_a   = '0;
    raddr_b   = '0;
    if (state == S_IDLE && accept) begin
      if (func == pas_pkg::FN_LOAD_A && a_count < CntW'(MAX_TERMS)) begin
        cmd.we_a = 1'b1;
        waddr    = AddrW'(a_count);
      end
      if (func == pas_pkg::FN_LOAD_B && b_count < CntW'(MAX_TERMS)) begin
        cmd.we_b = 1'b1;
        waddr    = AddrW'(b_count);
      end
    end
    if (state == S_RUN) begin
      cmd.rd_en     = 1'b1;
      cmd.is_mul    = is_mul;
      cmd.is_sub    = is_sub;
      cmd.first     = !is_mul || (step == '0);
      cmd.last_step = last_step;
      cmd.last_coef = (deg == '0);
      if (is_mul) begin
        cmd.use_a = use_mul;
        cmd.use_b = use_mul;
        raddr_a   = AddrW'(a_count - CntW'(1) - step);
        raddr_b   = AddrW'(DegW'(b_count) - DegW'(1) - j_deg[DegW-1:0]);
      end else begin
        cmd.use_a = use_a_add;
        cmd.use_b = use_b_add;
        raddr_a   = AddrW'(DegW'(a_count) - DegW'(1) - deg);
        raddr_b   = AddrW'(DegW'(b_count) - DegW'(1) - deg);
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      a_count <= '0;
      b_count <= '0;
      len     <= '0;
      deg     <= '0;
      step    <= '0;
      is_mul  <= 1'b0;
      is_sub  <= 1'b0;
      done    <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (func) inside
              pas_pkg::FN_LOAD_A: begin
                if (a_count < CntW'(MAX_TERMS)) begin
                  a_count <= a_count + CntW'(1);
                end
              end
              pas_pkg::FN_LOAD_B: begin
                if (b_count < CntW'(MAX_TERMS)) begin
                  b_count <= b_count + CntW'(1);
                end
              end
              pas_pkg::FN_ADD, pas_pkg::FN_SUB, pas_pkg::FN_MUL: begin
                is_mul <= (func == pas_pkg::FN_MUL);
                is_sub <= (func == pas_pkg::FN_SUB);
                len    <= len_start;
                done   <= 1'b0;
                if (func == pas_pkg::FN_MUL) begin
                  deg <= {len_start, 1'b0} - DegW'(2);
                end else begin
                  deg <= {1'b0, len_start} - DegW'(1);
                end
                state  <= S_WAIT;
              end
              default: begin
              end
            endcase
          end
        end
        S_WAIT: begin
          if (!sts.busy) begin
            if (done) begin
              a_count <= '0;
              b_count <= '0;
              state   <= S_IDLE;
            end else if (!sts.out_valid || out_ready) begin
              step  <= '0;
              state <= S_RUN;
            end
          end
        end
        S_RUN: begin
          if (last_step) begin
            if (deg == '0) begin
              done <= 1'b1;
            end else begin
              deg <= deg - DegW'(1);
            end
            state <= S_WAIT;
          end else begin
            step <= step + CntW'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // lengths stay within the stores
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (a_count <= CntW'(MAX_TERMS)) && (b_count <= CntW'(MAX_TERMS)))
    else $error("operand length beyond store depth");

  // no terms in flight once back in idle
  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !sts.busy)
    else $error("idle with terms in flight");

  // output register is free while a coefficient is being issued
  a_run_out_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> !sts.out_valid)
    else $error("issuing with output word pending");

  // lengths cleared at the end of a compute run
  a_clear_lengths: assert property (@(posedge clk) disable iff (rst)
    (state == S_WAIT && done && !sts.busy) |=> (a_count == '0 && b_count == '0))
    else $error("lengths not cleared after compute");

endmodule

// ===== test/polynomial_add_sub_mul_unit_tb.sv =====
// ----------------------------------------------------------------------------
// polynomial_add_sub_mul_unit_tb: self-checking bench for the polynomial unit
// A short directed run covers empty operands, unequal lengths and extreme
// coefficients. It is followed by random load/compute sequences with some
// noise, including overfull stores. A predictor in the bench works out each
// result word, and the monitor compares every output word against it. Both
// channels idle at random.
// ----------------------------------------------------------------------------
module polynomial_add_sub_mul_unit_tb;

  localparam int MAX_TERMS    = 32;
  localparam int PROD_TERMS   = 2 * MAX_TERMS - 1;
  localparam int RANDOM_ITEMS = 400;
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT  = 5000000;

  // func codes the unit does not decode
  localparam logic [pas_pkg::FUNC_W-1:0] FN_UNUSED_LO  = 3'd5;
  localparam logic [pas_pkg::FUNC_W-1:0] FN_UNUSED_MID = 3'd6;
  localparam logic [pas_pkg::FUNC_W-1:0] FN_UNUSED_HI  = 3'd7;

  typedef struct {
    logic [pas_pkg::FUNC_W-1:0]        op;
    logic signed [pas_pkg::COEF_W-1:0] coef;
  } in_word_t;

  typedef struct {
    logic signed [pas_pkg::OUT_W-1:0] coef;
    logic                             last;
  } coef_word_t;

  logic clk;
  logic rst;

  pas_in_if  in_ch ();
  pas_out_if out_ch ();

  polynomial_add_sub_mul_unit #(
    .MAX_TERMS(MAX_TERMS)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  in_word_t   pending_words[$];
  coef_word_t expected_coefs[$];
  int         mismatches = 0;
  int         cycle_count = 0;

  // operand stores as the unit should hold them
  logic signed [pas_pkg::COEF_W-1:0] a_store[MAX_TERMS];
  logic signed [pas_pkg::COEF_W-1:0] b_store[MAX_TERMS];
  int                                a_len = 0;
  int                                b_len = 0;

  // coefficient of degree d, zero beyond the loaded length
  function automatic longint term_at(bit from_a, int d);
    int n;
    n = from_a ? a_len : b_len;
    if (d >= n) return 0;
    return from_a ? longint'(a_store[n-1-d]) : longint'(b_store[n-1-d]);
  endfunction

  function automatic void push_coef(longint v, bit last);
    coef_word_t w;
    w.coef = v[pas_pkg::OUT_W-1:0];
    w.last = last;
    expected_coefs.push_back(w);
  endfunction

  // update operand state and queue the result words of one accepted word
  function automatic void predict_results(logic [pas_pkg::FUNC_W-1:0] op,
                                          logic signed [pas_pkg::COEF_W-1:0] coef);
    int     len;
    int     n;
    longint prod[PROD_TERMS];
    case (op) inside
      pas_pkg::FN_LOAD_A: begin
        if (a_len < MAX_TERMS) begin
          a_store[a_len] = coef;
          a_len++;
        end
      end
      pas_pkg::FN_LOAD_B: begin
        if (b_len < MAX_TERMS) begin
          b_store[b_len] = coef;
          b_len++;
        end
      end
      pas_pkg::FN_ADD, pas_pkg::FN_SUB, pas_pkg::FN_MUL: begin
        len = (a_len > b_len) ? a_len : b_len;
        if (len == 0) begin
          push_coef(0, 1'b1);
        end else if (op == pas_pkg::FN_MUL) begin
          foreach (prod[k]) prod[k] = 0;
          for (int i = 0; i < len; i++)
            for (int j = 0; j < len; j++)
              prod[i+j] += term_at(1'b1, i) * term_at(1'b0, j);
          n = 2 * len - 1;
          for (int k = 0; k < n; k++) push_coef(prod[n-1-k], k == n - 1);
        end else begin
          for (int k = 0; k < len; k++) begin
            if (op == pas_pkg::FN_ADD)
              push_coef(term_at(1'b1, len-1-k) + term_at(1'b0, len-1-k), k == len - 1);
            else
              push_coef(term_at(1'b1, len-1-k) - term_at(1'b0, len-1-k), k == len - 1);
          end
        end
        a_len = 0;
        b_len = 0;
      end
      default: ;
    endcase
  endfunction

  function automatic void push_word(logic [pas_pkg::FUNC_W-1:0] op,
                                    logic signed [pas_pkg::COEF_W-1:0] coef);
    in_word_t w;
    w.op   = op;
    w.coef = coef;
    pending_words.push_back(w);
  endfunction

  // coefficient with a bias towards the extremes
  function automatic logic signed [pas_pkg::COEF_W-1:0] rand_coef();
    logic [31:0] r;
    r = $urandom();
    if ($urandom_range(0, 99) < 20) begin
      case ($urandom_range(0, 4))
        0: return 16'sh7fff;
        1: return 16'sh8000;
        2: return 16'sh0000;
        3: return 16'shffff;
        default: return 16'sh0001;
      endcase
    end
    return r[pas_pkg::COEF_W-1:0];
  endfunction

  // operand length: mostly short, sometimes long, now and then overfull
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return $urandom_range(MAX_TERMS - 2, MAX_TERMS + 2);
    if (r < 30) return $urandom_range(0, MAX_TERMS);
    return $urandom_range(0, 6);
  endfunction

  // clock and reset
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
  end

  // stimulus: directed words, random sequences, then wait for the tail
  initial begin : stimulus
    int                         effective;
    int                         a_n;
    int                         b_n;
    logic [pas_pkg::FUNC_W-1:0] op;

    // both operands empty
    push_word(pas_pkg::FN_ADD, 16'sh1234);
    push_word(pas_pkg::FN_MUL, 16'sh7fff);
    push_word(FN_UNUSED_LO, 16'sh7fff);
    // a longer than b, extreme values
    push_word(pas_pkg::FN_LOAD_A, 16'sh7fff);
    push_word(pas_pkg::FN_LOAD_A, 16'sh8000);
    push_word(pas_pkg::FN_LOAD_B, 16'sh8000);
    push_word(pas_pkg::FN_MUL, 16'sh0000);
    // a shorter than b, so a is the one padded
    push_word(pas_pkg::FN_LOAD_A, 16'sh8000);
    push_word(pas_pkg::FN_LOAD_B, 16'sh7fff);
    push_word(pas_pkg::FN_LOAD_B, 16'shffff);
    push_word(pas_pkg::FN_LOAD_B, 16'sh0000);
    push_word(FN_UNUSED_MID, 16'sh8000);
    push_word(FN_UNUSED_HI, 16'shffff);
    push_word(pas_pkg::FN_SUB, 16'sh5555);
    push_word(pas_pkg::FN_LOAD_A, 16'sh0001);
    push_word(pas_pkg::FN_LOAD_B, 16'sh8000);
    push_word(pas_pkg::FN_ADD, 16'shaaaa);
    // one operand empty
    push_word(pas_pkg::FN_LOAD_B, 16'sh0005);
    push_word(pas_pkg::FN_SUB, 16'sh0000);
    push_word(pas_pkg::FN_LOAD_A, 16'sh8000);
    push_word(pas_pkg::FN_MUL, 16'sh0000);
    push_word(pas_pkg::FN_SUB, 16'sh0000);

    // random sequences with some noise
    effective = 0;
    while (effective < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 12) begin
        op = pas_pkg::FUNC_W'($urandom_range(0, 7));
        push_word(op, rand_coef());
        if (op <= pas_pkg::FN_MUL) effective++;
      end else begin
        a_n = pick_len();
        b_n = pick_len();
        effective += ((a_n < MAX_TERMS) ? a_n : MAX_TERMS) +
                     ((b_n < MAX_TERMS) ? b_n : MAX_TERMS) + 1;
        while (a_n > 0 || b_n > 0) begin
          if ($urandom_range(0, 99) < 3) begin
            op = pas_pkg::FUNC_W'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
            push_word(op, rand_coef());
          end
          if (b_n == 0 || (a_n > 0 && $urandom_range(0, 1) == 1)) begin
            push_word(pas_pkg::FN_LOAD_A, rand_coef());
            a_n--;
          end else begin
            push_word(pas_pkg::FN_LOAD_B, rand_coef());
            b_n--;
          end
        end
        op = pas_pkg::FUNC_W'($urandom_range(pas_pkg::FN_ADD, pas_pkg::FN_MUL));
        push_word(op, rand_coef());
      end
    end

    while (pending_words.size() != 0 || in_ch.valid) @(negedge clk);
    while (expected_coefs.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // sender: bursts of words with random gaps
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin : driver
    in_word_t nxt;
    if (rst) begin
      in_ch.valid   <= 1'b0;
      in_ch.func    <= pas_pkg::FN_LOAD_A;
      in_ch.coef_in <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_results(in_ch.func, in_ch.coef_in);
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left    <= gap_left - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          nxt = pending_words.pop_front();
          in_ch.valid   <= 1'b1;
          in_ch.func    <= nxt.op;
          in_ch.coef_in <= nxt.coef;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall mode is redrawn at random intervals
  int stall_mode = 0;
  int mode_cycles = 0;

  always @(posedge clk) begin
    if (mode_cycles == 0) begin
      stall_mode  <= $urandom_range(0, 3);
      mode_cycles <= $urandom_range(100, 400);
    end else begin
      mode_cycles <= mode_cycles - 1;
    end
    case (stall_mode)
      0:       out_ch.ready <= 1'b1;
      1:       out_ch.ready <= ($urandom_range(0, 99) >= 25);
      2:       out_ch.ready <= ($urandom_range(0, 99) >= 75);
      default: out_ch.ready <= (cycle_count % 4 == 0);
    endcase
  end

  // monitor: compare each result word with the oldest expectation
  always @(posedge clk) begin : monitor
    coef_word_t exp_w;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_coefs.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word, expected none, got coef_out %0d last_coef %0b",
                 $time, out_ch.coef_out, out_ch.last_coef);
      end else begin
        exp_w = expected_coefs.pop_front();
        if (out_ch.coef_out !== exp_w.coef) begin
          mismatches++;
          $display("%0t: coef_out mismatch, expected %0d, got %0d",
                   $time, exp_w.coef, out_ch.coef_out);
        end
        if (out_ch.last_coef !== exp_w.last) begin
          mismatches++;
          $display("%0t: last_coef mismatch, expected %0b, got %0b",
                   $time, exp_w.last, out_ch.last_coef);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule

// ===== polynomial_add_sub_mul_unit.f =====
sv/pas_pkg.sv
sv/pas_in_if.sv
sv/pas_out_if.sv
sv/pas_ram.sv
sv/pas_dp.sv
sv/pas_ctrl.sv
sv/polynomial_add_sub_mul_unit.sv
test/polynomial_add_sub_mul_unit_tb.sv
